// ===== hw/rtl/hipc_pkg.sv =====
// Package: item types, register codes and sizes for the indexed pixel colorizer.
package hipc_pkg;

  localparam int unsigned PalEntries = 256;
  localparam int unsigned PalAw      = $clog2(PalEntries);
  localparam int unsigned ColorW     = 24;

  localparam logic [3:0] DepthReset = 4'd8;
  localparam logic [3:0] DepthMax   = 4'd8;
  localparam logic [3:0] HamMinDep  = 4'd5;
  localparam logic [3:0] HamShBase  = 4'd10;
  localparam logic [7:0] AlphaOpaque = 8'hff;
  localparam logic [7:0] AlphaClear  = 8'h00;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModePixel = 1'b1;

  typedef enum logic [1:0] {
    RegPlaneDepth  = 2'd0,
    RegHamEnable   = 2'd1,
    RegTranspEn    = 2'd2,
    RegTranspIndex = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HamLookup = 2'd0,
    HamBlue   = 2'd1,
    HamRed    = 2'd2,
    HamGreen  = 2'd3
  } ham_ctl_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] data;
  } cfg_item_t;

endpackage

// ===== hw/rtl/hipc_in_if.sv =====
// Interface: input item channel (palette loads and pixels).
interface hipc_in_if
  import hipc_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hipc_out_if.sv =====
// Interface: result item channel (RGBA pixels).
interface hipc_out_if
  import hipc_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hipc_cfg_if.sv =====
// Interface: configuration register write channel.
interface hipc_cfg_if
  import hipc_pkg::*;
;
  logic      valid;
  logic      ready;
  cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hipc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hipc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ham_indexed_pixel_colorizer_top.sv =====
// Top level: palette / hold-and-modify pixel colorizer.
//
//  channel   | dir | payload                                   | handshake
//  pix_in    | in  | mode, index, entry_rgb, start_of_image    | valid/ready
//  pix_out   | out | out_red, out_green, out_blue, out_alpha   | valid/ready
//  cfg_in    | in  | register index, write data                | valid/ready
//
// One item per cycle sustained while the output is not stalled; a pixel's result passes through
// the palette RAM read, then color select and hold update, before it shows. Loads give no result.
// Reset returns config to its defaults, clears held color and valid flags; palette stays unwritten.
// A stalled output holds the result; input ready drops only when both stages are full.
module ham_indexed_pixel_colorizer_top
  import hipc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hipc_in_if.sink     pix_in,
  hipc_out_if.source  pix_out,
  hipc_cfg_if.sink    cfg_in
);

  // config registers
  logic [3:0] depth_q;
  logic       ham_en_q;
  logic       tr_en_q;
  logic [7:0] tr_idx_q;

  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= DepthReset;
      ham_en_q <= 1'b0;
      tr_en_q  <= 1'b0;
      tr_idx_q <= 8'd0;
    end else if (cfg_in.valid) begin
      unique case (cfg_reg_e'(cfg_in.data.index))
        RegPlaneDepth:  depth_q  <= cfg_in.data.data[3:0];
        RegHamEnable:   ham_en_q <= cfg_in.data.data[0];
        RegTranspEn:    tr_en_q  <= cfg_in.data.data[0];
        RegTranspIndex: tr_idx_q <= cfg_in.data.data;
        default: ;
      endcase
    end
  end

  // stage 0: decode input item
  logic       s1_valid_q, out_valid_q;
  logic       out_free, s1_free, in_acc;
  logic [3:0] depth_eff;
  logic       ham_on;
  logic [2:0] ham_sh, ctl_sh;
  logic [7:0] lo, mod;
  logic [1:0] ctl;
  logic [PalAw-1:0] rd_addr;
  logic [ColorW-1:0] rd_data;

  assign out_free     = !out_valid_q || pix_out.ready;
  assign s1_free      = !s1_valid_q || out_free;
  assign pix_in.ready = s1_free;
  assign in_acc       = pix_in.valid && s1_free;

  always_comb begin
    depth_eff = (depth_q > DepthMax) ? DepthMax : depth_q;
    ham_on    = ham_en_q && (depth_eff >= HamMinDep);
    ham_sh    = 3'(HamShBase - depth_eff);
    ctl_sh    = 3'(depth_eff - 4'd2);
    ctl       = 2'(pix_in.data.index >> ctl_sh);
    lo        = pix_in.data.index & (8'hff >> ham_sh);
    mod       = 8'(lo << ham_sh);
    rd_addr   = ham_on ? PalAw'(lo) : PalAw'(pix_in.data.index);
  end

  hipc_ram #(
    .Width (ColorW),
    .Depth (PalEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (in_acc && (pix_in.data.mode == ModeLoad)),
    .waddr_i (PalAw'(pix_in.data.index)),
    .wdata_i ({pix_in.data.entry_red, pix_in.data.entry_green, pix_in.data.entry_blue}),
    .re_i    (in_acc && (pix_in.data.mode == ModePixel)),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // stage 1: color select and hold update
  logic       s1_ham_q, s1_sof_q, s1_clear_q;
  logic [1:0] s1_ctl_q;
  logic [7:0] s1_mod_q;
  logic [7:0] held_r_q, held_g_q, held_b_q;
  logic [7:0] held_r_d, held_g_d, held_b_d;
  logic [7:0] base_r, base_g, base_b;
  out_item_t  res_d, out_q;
  logic       s1_move;

  assign s1_move = s1_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_acc && (pix_in.data.mode == ModePixel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ham_q   <= ham_on;
      s1_sof_q   <= pix_in.data.start_of_image;
      s1_ctl_q   <= ctl;
      s1_mod_q   <= mod;
      s1_clear_q <= !ham_on && tr_en_q && (pix_in.data.index == tr_idx_q);
    end
  end

  always_comb begin
    base_r   = s1_sof_q ? 8'd0 : held_r_q;
    base_g   = s1_sof_q ? 8'd0 : held_g_q;
    base_b   = s1_sof_q ? 8'd0 : held_b_q;
    held_r_d = base_r;
    held_g_d = base_g;
    held_b_d = base_b;
    if (s1_ham_q) begin
      unique case (ham_ctl_e'(s1_ctl_q))
        HamLookup: begin
          held_r_d = rd_data[23:16];
          held_g_d = rd_data[15:8];
          held_b_d = rd_data[7:0];
        end
        HamBlue:  held_b_d = s1_mod_q;
        HamRed:   held_r_d = s1_mod_q;
        HamGreen: held_g_d = s1_mod_q;
        default: ;
      endcase
      res_d = '{held_r_d, held_g_d, held_b_d, AlphaOpaque};
    end else begin
      res_d = '{rd_data[23:16], rd_data[15:8], rd_data[7:0],
                s1_clear_q ? AlphaClear : AlphaOpaque};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_r_q    <= 8'd0;
      held_g_q    <= 8'd0;
      held_b_q    <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_move) begin
        held_r_q <= held_r_d;
        held_g_q <= held_g_d;
        held_b_q <= held_b_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= res_d;
    end
  end

  assign pix_out.valid = out_valid_q;
  assign pix_out.data  = out_q;

endmodule
